// ===== hdl/crfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crfl_pkg
// Shared constants, opcode and status codes, and the result record of the
// contiguous-run free list.
// ----------------------------------------------------------------------------
package crfl_pkg;

	// Default number of list entries
	localparam int CRFL_CAPACITY = 256;

	// Field widths fixed by the channel definitions
	localparam int SLOT_W = 32;
	localparam int LEN_W  = 9;
	localparam int POS_W  = 8;
	localparam int STAT_W = 2;

	// Opcodes
	localparam logic OP_FREE  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_FREED     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_FOUND     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	// One result record
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] start_index;
		logic [POS_W-1:0]  list_position;
		logic [LEN_W-1:0]  run_count;
		logic [LEN_W-1:0]  entries_left;
	} crfl_res_t;

endpackage
`default_nettype wire

// ===== hdl/crfl_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crfl_req_if
// Request channel: one free or allocate command per transfer.
// ----------------------------------------------------------------------------
interface crfl_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] slot_index;
	logic [8:0]  run_length;

	modport source (output valid, output opcode, output slot_index, output run_length,
		input ready);
	modport sink (input valid, input opcode, input slot_index, input run_length,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/crfl_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crfl_rsp_if
// Response channel: one result record per transfer.
// ----------------------------------------------------------------------------
interface crfl_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] start_index;
	logic [7:0]  list_position;
	logic [8:0]  run_count;
	logic [8:0]  entries_left;

	modport source (output valid, output status, output start_index,
		output list_position, output run_count, output entries_left, input ready);
	modport sink (input valid, input status, input start_index,
		input list_position, input run_count, input entries_left, output ready);
endinterface
`default_nettype wire

// ===== hdl/crfl_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crfl_core
// Sorted list storage and the sequencer that walks it: insertion with
// shift-up for frees, first-fit run scan and compaction for allocates.
// ----------------------------------------------------------------------------
module crfl_core
	import crfl_pkg::*;
#(
	parameter int CAPACITY = CRFL_CAPACITY
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	crfl_req_if.sink       req,
	output logic           res_valid,
	input  wire logic      res_ready,
	output crfl_res_t      res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int NW = (CW > LEN_W) ? CW : LEN_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FREE = 3'd1;
	localparam logic [2:0] S_PUT  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_MOVE = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	// List storage, one write and one read port
	logic [SLOT_W-1:0] mem [CAPACITY];
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [SLOT_W-1:0] wr_data;
	logic              rd_en;
	logic [SLOT_W-1:0] rd_data_s1;
	logic              rv_s1;

	// Sequencer state
	logic [2:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     newcnt_q;
	logic [AW-1:0]     rd_ptr_q;
	logic              rd_more_q;
	logic [AW-1:0]     pos_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     wr_ptr_q;
	logic [LEN_W-1:0]  run_q;
	logic [LEN_W-1:0]  need_q;
	logic [SLOT_W-1:0] value_q;
	logic [SLOT_W-1:0] prev_q;
	crfl_res_t         res_q;

	// Derived values
	logic [AW-1:0]     cnt_m1;
	logic [AW-1:0]     newcnt_m1;
	logic [NW-1:0]     cnt_n;
	logic [NW-1:0]     cnt_p1_n;
	logic [NW-1:0]     need_n;
	logic [NW-1:0]     first_n;
	logic [NW-1:0]     newcnt_n;
	logic [LEN_W-1:0]  run_n;
	logic              shift;
	logic              hit;
	logic              last;
	logic              full;
	logic              seq_stop;

	assign cnt_m1    = AW'(cnt_q - 1'b1);
	assign newcnt_m1 = AW'(newcnt_q - 1'b1);
	assign cnt_n     = NW'(cnt_q);
	assign cnt_p1_n  = cnt_n + NW'(1);
	assign need_n    = NW'(need_q);
	assign first_n   = NW'(idx_q) + NW'(1) - need_n;
	assign newcnt_n  = cnt_n - need_n;
	assign full      = (cnt_q == CW'(CAPACITY));

	// Run tracking: an entry extends the run only if exactly one above the last
	assign run_n = ((idx_q != '0) && (rd_data_s1 == prev_q + 32'd1)) ?
		run_q + 1'b1 : LEN_W'(1);
	assign hit   = (run_n == need_q);
	assign last  = (idx_q == cnt_m1);
	assign shift = (rd_data_s1 > value_q);

	assign rd_en     = rd_more_q;
	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// Last useful read data of a walk; the read in flight is dropped
	always_comb begin
		seq_stop = 1'b0;
		case (state_q)
			S_FREE: begin
				seq_stop = rv_s1 && (!shift || (pos_q == AW'(1)));
			end
			S_SCAN: begin
				seq_stop = rv_s1 && (hit || last);
			end
			S_MOVE: begin
				seq_stop = rv_s1 && (wr_ptr_q == newcnt_m1);
			end
			default: begin
				seq_stop = 1'b0;
			end
		endcase
	end

	// Write port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = value_q;
		case (state_q)
			S_FREE: begin
				wr_en   = rv_s1 && shift;
				wr_data = rd_data_s1;
			end
			S_PUT: begin
				wr_en = 1'b1;
			end
			S_MOVE: begin
				wr_en   = rv_s1;
				wr_addr = wr_ptr_q;
				wr_data = rd_data_s1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_ptr_q];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rv_s1     <= 1'b0;
			rd_more_q <= 1'b0;
			rd_ptr_q  <= '0;
		end else begin
			rv_s1 <= rd_en && !seq_stop;

			// Read pointer walks down for inserts, up for scans and moves
			if (rd_en && !seq_stop) begin
				if (state_q == S_FREE) begin
					if (rd_ptr_q == '0) begin
						rd_more_q <= 1'b0;
					end else begin
						rd_ptr_q <= rd_ptr_q - 1'b1;
					end
				end else begin
					if (rd_ptr_q == cnt_m1) begin
						rd_more_q <= 1'b0;
					end else begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						value_q <= req.slot_index;
						need_q  <= req.run_length;
						if (req.opcode == OP_FREE) begin
							if (full) begin
								res_q   <= '{ST_FULL, '0, '0, '0, cnt_n[LEN_W-1:0]};
								state_q <= S_DONE;
							end else if (cnt_q == '0) begin
								pos_q   <= '0;
								state_q <= S_PUT;
							end else begin
								pos_q     <= AW'(cnt_q);
								rd_ptr_q  <= cnt_m1;
								rd_more_q <= 1'b1;
								state_q   <= S_FREE;
							end
						end else begin
							if ((req.run_length == '0) || (NW'(req.run_length) > cnt_n)) begin
								res_q   <= '{ST_NOT_FOUND, '0, '0, '0, cnt_n[LEN_W-1:0]};
								state_q <= S_DONE;
							end else begin
								idx_q     <= '0;
								run_q     <= '0;
								rd_ptr_q  <= '0;
								rd_more_q <= 1'b1;
								state_q   <= S_SCAN;
							end
						end
					end
				end
				S_FREE: begin
					// Entry above the value moves up one place; stop at first one not above it
					if (rv_s1) begin
						if (shift) begin
							pos_q <= pos_q - 1'b1;
							if (pos_q == AW'(1)) begin
								rd_more_q <= 1'b0;
								state_q   <= S_PUT;
							end
						end else begin
							rd_more_q <= 1'b0;
							state_q   <= S_PUT;
						end
					end
				end
				S_PUT: begin
					cnt_q   <= cnt_q + 1'b1;
					res_q   <= '{ST_FREED, '0, '0, '0, cnt_p1_n[LEN_W-1:0]};
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (rv_s1) begin
						prev_q <= rd_data_s1;
						run_q  <= run_n;
						idx_q  <= idx_q + 1'b1;
						if (hit) begin
							res_q <= '{ST_FOUND, rd_data_s1 - SLOT_W'(need_q) + 32'd1,
								first_n[POS_W-1:0], need_q, newcnt_n[LEN_W-1:0]};
							newcnt_q <= CW'(newcnt_n);
							if (last) begin
								// Run ends at the top of the list: nothing to move
								cnt_q     <= CW'(newcnt_n);
								rd_more_q <= 1'b0;
								state_q   <= S_DONE;
							end else begin
								wr_ptr_q  <= AW'(first_n);
								rd_ptr_q  <= idx_q + 1'b1;
								rd_more_q <= 1'b1;
								state_q   <= S_MOVE;
							end
						end else if (last) begin
							res_q     <= '{ST_NOT_FOUND, '0, '0, '0, cnt_n[LEN_W-1:0]};
							rd_more_q <= 1'b0;
							state_q   <= S_DONE;
						end
					end
				end
				S_MOVE: begin
					// Close the gap, one entry per cycle
					if (rv_s1) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
						if (wr_ptr_q == newcnt_m1) begin
							cnt_q     <= newcnt_q;
							rd_more_q <= 1'b0;
							state_q   <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/crfl_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crfl_out_reg
// Output register: holds one finished result so the sequencer can take
// the next command while the consumer stalls.
// ----------------------------------------------------------------------------
module crfl_out_reg
	import crfl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      res_valid,
	output logic           res_ready,
	input  wire crfl_res_t res,
	crfl_rsp_if.source     rsp
);

	logic      valid_q;
	crfl_res_t data_q;

	assign res_ready = !valid_q || rsp.ready;

	// Load on a new result, drop after a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				valid_q <= 1'b1;
				data_q  <= res;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.status        = data_q.status;
	assign rsp.start_index   = data_q.start_index;
	assign rsp.list_position = data_q.list_position;
	assign rsp.run_count     = data_q.run_count;
	assign rsp.entries_left  = data_q.entries_left;

endmodule
`default_nettype wire

// ===== hdl/contiguous_run_free_list.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_run_free_list
// Sorted free list of slot indices with first-fit allocation of runs of
// consecutive indices.
// ----------------------------------------------------------------------------
//  Port   Direction  Transfer carries
//  req    in         opcode, slot_index, run_length (one command)
//  rsp    out        status, start_index, list_position, run_count,
//                    entries_left (one result per command)
//
//  One command is worked at a time, walking the list memory one entry per
//  cycle through its single read and write port. A free moves each
//  entry above the freed index up one place; an allocate scans for the
//  first fitting run, then moves the entries above it down. A full-list
//  free or a request that can never match ends without a walk. Reset
//  clears the entry count and control state; the memory is not swept.
//  A held result sits in the output register; the next command is taken
//  meanwhile and its result waits until that register frees.
// ----------------------------------------------------------------------------
module contiguous_run_free_list
	import crfl_pkg::*;
#(
	parameter int CAPACITY = CRFL_CAPACITY
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	crfl_req_if.sink   req,
	crfl_rsp_if.source rsp
);

	logic      res_valid;
	logic      res_ready;
	crfl_res_t res;

	// List memory and sequencer
	crfl_core #(
		.CAPACITY (CAPACITY)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Result holding register
	crfl_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
